@@ sv/nau_pkg.sv @@
package nau_pkg;

    typedef enum logic [2:0] {
        KIND_LINEAR    = 3'd0,
        KIND_TANH      = 3'd1,
        KIND_SHIFT_EXP = 3'd2,
        KIND_SIGMOID   = 3'd3,
        KIND_SQUARE    = 3'd4,
        KIND_EXP       = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        REG_FUNCTION_KIND = 3'd0,
        REG_TANH_GAIN     = 3'd1,
        REG_SIGMOID_GAIN  = 3'd2,
        REG_EXP_CENTER    = 3'd3,
        REG_EXP_INV_SCALE = 3'd4
    } reg_idx_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic signed [15:0] TANH_GAIN_RST     = 16'sd1024;
    localparam logic signed [15:0] SIGMOID_GAIN_RST  = 16'sd1024;
    localparam logic signed [15:0] EXP_CENTER_RST    = 16'sd7168;
    localparam logic signed [15:0] EXP_INV_SCALE_RST = 16'sd1024;

    localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
    localparam logic signed [31:0] ONE_Q16   = 32'sd65536;
    localparam logic signed [31:0] SAT_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN   = 32'sh8000_0000;

    // quotient bits of the tanh / sigmoid divider, one per stage
    localparam int DIV_STEPS = 18;

    typedef struct packed {
        kind_t                kind;
        logic signed [15:0]   x;
        logic signed [15:0]   inv_s;
        logic                 neg;
        logic signed [31:0]   prod_a;
        logic signed [32:0]   prod_ds;
        logic signed [26:0]   arg;
        logic signed [57:0]   lg;
        logic signed [7:0]    n;
        logic [31:0]          t0;
        logic [31:0]          diff;
        logic [15:0]          rem;
        logic [47:0]          ip;
        logic [31:0]          m;
        logic [31:0]          e_val;
        logic                 e_ovf;
        logic signed [48:0]   sp;
        logic [35:0]          num;
        logic [17:0]          den;
        logic [17:0]          rmd;
        logic [17:0]          quo;
        logic signed [31:0]   act;
        logic signed [17:0]   op_a;
        logic signed [17:0]   op_b;
        logic signed [35:0]   pm;
        logic signed [31:0]   slope;
        logic                 ovf;
    } pipe_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] cand;
        res = '0;
        for (int k = 31; k >= 0; k--) begin
            cand = res | (64'd1 << k);
            if (cand * cand <= v)
                res = cand;
        end
        return res;
    endfunction

    // 2^(i / 2^b) in Q2.30, built from repeated square roots of two
    function automatic logic [31:0] pow2_entry(input int b, input int i);
        logic [63:0] root [13];
        logic [63:0] v;
        if (i >= (1 << b))
            return 32'h8000_0000;
        root[0] = 64'd1 << 31;
        for (int k = 1; k <= b; k++)
            root[k] = isqrt64(root[k-1] << 30);
        v = 64'd1 << 30;
        for (int j = 0; j < b; j++)
            if (((i >> j) & 1) != 0)
                v = (v * root[b-j] + (64'd1 << 29)) >> 30;
        return v[31:0];
    endfunction

endpackage

@@ sv/nau_if.sv @@
interface nau_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface nau_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] activation_out;
    logic signed [31:0] slope_out;
    logic               overflow;

    modport source (output valid, output activation_out, output slope_out, output overflow,
                    input ready);
    modport sink   (input valid, input activation_out, input slope_out, input overflow,
                    output ready);
endinterface

@@ sv/neural_activation_unit.sv @@
// channel   | dir | payload                                   | transfer when
// ----------+-----+-------------------------------------------+------------------
// sample    | in  | sample_in (Q5.10)                         | valid & ready
// result    | out | activation_out, slope_out (Q15.16), ovfl  | valid & ready
// cfg       | in  | cfg_index, cfg_data                       | cfg_write
//
// One sample per cycle through 29 register stages while the result side does not stall;
// 18 of the stages form the one-bit-per-stage divider shared by tanh and sigmoid.
// rst_n clears the stage valid bits and the config registers at once.
// Each stage moves on when it or the one after it is free, so bubbles close up
// and a sample is still taken while the result register waits.
module neural_activation_unit #(
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    nau_sample_if.sink                        sample,
    nau_result_if.source                      result,
    input  logic                              cfg_write,
    input  logic [nau_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [nau_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ENTRIES = 1 << EXP_TABLE_BITS;
    localparam int SH      = 16 - EXP_TABLE_BITS;

    localparam int S_MUL  = 0;
    localparam int S_ARG  = 1;
    localparam int S_LOG  = 2;
    localparam int S_TAB  = 3;
    localparam int S_IPM  = 4;
    localparam int S_MAN  = 5;
    localparam int S_SCL  = 6;
    localparam int S_PRE  = 7;
    localparam int S_DIV0 = 8;
    localparam int S_ACT  = S_DIV0 + nau_pkg::DIV_STEPS;
    localparam int S_PRD  = S_ACT + 1;
    localparam int S_OUT  = S_PRD + 1;
    localparam int NS     = S_OUT + 1;

    // config registers
    nau_pkg::kind_t     kind_reg;
    logic signed [15:0] tanh_gain_reg;
    logic signed [15:0] sigmoid_gain_reg;
    logic signed [15:0] exp_center_reg;
    logic signed [15:0] exp_inv_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg          <= nau_pkg::KIND_LINEAR;
            tanh_gain_reg     <= nau_pkg::TANH_GAIN_RST;
            sigmoid_gain_reg  <= nau_pkg::SIGMOID_GAIN_RST;
            exp_center_reg    <= nau_pkg::EXP_CENTER_RST;
            exp_inv_scale_reg <= nau_pkg::EXP_INV_SCALE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                nau_pkg::REG_FUNCTION_KIND: kind_reg <= nau_pkg::kind_t'(cfg_data[2:0]);
                nau_pkg::REG_TANH_GAIN:     tanh_gain_reg     <= cfg_data;
                nau_pkg::REG_SIGMOID_GAIN:  sigmoid_gain_reg  <= cfg_data;
                nau_pkg::REG_EXP_CENTER:    exp_center_reg    <= cfg_data;
                nau_pkg::REG_EXP_INV_SCALE: exp_inv_scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // 2^f table
    logic [31:0] pow2_tab [ENTRIES+1];
    for (genvar gi = 0; gi <= ENTRIES; gi++)
    begin : g_tab
        assign pow2_tab[gi] = nau_pkg::pow2_entry(EXP_TABLE_BITS, gi);
    end

    // pipeline
    nau_pkg::pipe_t st_reg  [NS];
    nau_pkg::pipe_t st_next [NS];
    logic           v_reg   [NS];
    logic           v_next  [NS];
    logic           en      [NS];

    assign en[NS-1] = !v_reg[NS-1] || result.ready;
    for (genvar ge = 0; ge < NS - 1; ge++)
    begin : g_en
        assign en[ge] = !v_reg[ge] || en[ge+1];
    end

    assign v_next[0] = sample.valid;
    for (genvar gk = 0; gk < NS; gk++)
    begin : g_stage
        if (gk > 0)
        begin : g_vn
            assign v_next[gk] = v_reg[gk-1];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[gk] <= 1'b0;
            else if (en[gk])
                v_reg[gk] <= v_next[gk];
        end
        always_ff @(posedge clk)
        begin
            if (en[gk])
                st_reg[gk] <= st_next[gk];
        end
    end

    assign sample.ready          = en[0];
    assign result.valid          = v_reg[NS-1];
    assign result.activation_out = st_reg[NS-1].act;
    assign result.slope_out      = st_reg[NS-1].slope;
    assign result.overflow       = st_reg[NS-1].ovf;

    // products of gain and sample, and of offset and inverse scale
    logic signed [15:0] gain;
    logic signed [16:0] offs;
    always_comb
    begin
        gain = (kind_reg == nau_pkg::KIND_TANH) ? tanh_gain_reg : sigmoid_gain_reg;
        offs = 17'(sample.sample_in) - 17'(exp_center_reg);
        st_next[S_MUL]         = '0;
        st_next[S_MUL].kind    = kind_reg;
        st_next[S_MUL].x       = sample.sample_in;
        st_next[S_MUL].inv_s   = exp_inv_scale_reg;
        st_next[S_MUL].prod_a  = 32'(gain) * 32'(sample.sample_in);
        st_next[S_MUL].prod_ds = 33'(offs) * 33'(exp_inv_scale_reg);
    end

    // exponent argument in Q.20, clamped to [-32, 16]
    logic signed [33:0] mag_a;
    logic signed [34:0] raw_arg;
    always_comb
    begin
        st_next[S_ARG]     = st_reg[S_ARG-1];
        st_next[S_ARG].neg = st_reg[S_ARG-1].prod_a < 0;
        mag_a = st_next[S_ARG].neg ? -34'(st_reg[S_ARG-1].prod_a)
                                   : 34'(st_reg[S_ARG-1].prod_a);
        unique case (st_reg[S_ARG-1].kind)
            nau_pkg::KIND_TANH:      raw_arg = -(35'(mag_a) <<< 1);
            nau_pkg::KIND_SIGMOID:   raw_arg = -35'(mag_a);
            nau_pkg::KIND_SHIFT_EXP: raw_arg = -35'(st_reg[S_ARG-1].prod_ds);
            nau_pkg::KIND_EXP:       raw_arg = 35'(st_reg[S_ARG-1].x) <<< 10;
            default:                 raw_arg = '0;
        endcase
        if (raw_arg < -(35'sd1 <<< 25))
            st_next[S_ARG].arg = -(27'sd1 <<< 25);
        else if (raw_arg > (35'sd1 <<< 24))
            st_next[S_ARG].arg = 27'sd1 <<< 24;
        else
            st_next[S_ARG].arg = raw_arg[26:0];
    end

    always_comb
    begin
        st_next[S_LOG]    = st_reg[S_LOG-1];
        st_next[S_LOG].lg = 58'(st_reg[S_LOG-1].arg) * 58'(nau_pkg::LOG2E_Q30);
    end

    // split log2 value into integer part and table index / remainder
    logic signed [23:0]          e_q16;
    logic [EXP_TABLE_BITS-1:0]   idx;
    logic [EXP_TABLE_BITS:0]     idx_hi;
    logic [SH-1:0]               rem;
    logic [31:0]                 t1;
    always_comb
    begin
        e_q16  = st_reg[S_TAB-1].lg[57:34];
        idx    = e_q16[15:SH];
        rem    = e_q16[SH-1:0];
        idx_hi = {1'b0, idx} + 1'b1;
        t1     = pow2_tab[idx_hi];
        st_next[S_TAB]      = st_reg[S_TAB-1];
        st_next[S_TAB].n    = e_q16[23:16];
        st_next[S_TAB].t0   = pow2_tab[{1'b0, idx}];
        st_next[S_TAB].diff = t1 - pow2_tab[{1'b0, idx}];
        st_next[S_TAB].rem  = 16'(rem);
    end

    always_comb
    begin
        st_next[S_IPM]    = st_reg[S_IPM-1];
        st_next[S_IPM].ip = 48'(st_reg[S_IPM-1].diff) * 48'(st_reg[S_IPM-1].rem);
    end

    always_comb
    begin
        st_next[S_MAN]   = st_reg[S_MAN-1];
        st_next[S_MAN].m = st_reg[S_MAN-1].t0 + 32'(st_reg[S_MAN-1].ip >> SH);
    end

    // scale Q2.30 mantissa by 2^n into Q16, rounding half up
    logic signed [8:0] sa;
    logic [32:0]       rounded;
    always_comb
    begin
        sa      = 9'sd14 - 9'(st_reg[S_SCL-1].n);
        rounded = '0;
        st_next[S_SCL]       = st_reg[S_SCL-1];
        st_next[S_SCL].e_ovf = 1'b0;
        if (st_reg[S_SCL-1].n >= 8'sd15)
        begin
            st_next[S_SCL].e_val = 32'h7FFF_FFFF;
            st_next[S_SCL].e_ovf = 1'b1;
        end
        else if (sa == 9'sd0)
            st_next[S_SCL].e_val = st_reg[S_SCL-1].m;
        else if (sa >= 9'sd32)
            st_next[S_SCL].e_val = '0;
        else
        begin
            rounded = (33'(st_reg[S_SCL-1].m) + (33'd1 << (sa[4:0] - 5'd1))) >> sa[4:0];
            st_next[S_SCL].e_val = rounded[31:0];
        end
    end

    // divider operands, shifted-exp slope product
    logic [32:0] dsum;
    logic [16:0] one_minus_e;
    always_comb
    begin
        dsum        = 33'(st_reg[S_PRE-1].e_val) + 33'(nau_pkg::ONE_Q16);
        one_minus_e = 17'(32'(nau_pkg::ONE_Q16) - st_reg[S_PRE-1].e_val);
        st_next[S_PRE]     = st_reg[S_PRE-1];
        st_next[S_PRE].den = dsum[17:0];
        st_next[S_PRE].quo = '0;
        st_next[S_PRE].sp  = 49'(st_reg[S_PRE-1].inv_s) *
                             $signed({17'b0, st_reg[S_PRE-1].e_val});
        unique case (st_reg[S_PRE-1].kind)
            nau_pkg::KIND_TANH:    st_next[S_PRE].num = 36'(one_minus_e) << 17;
            nau_pkg::KIND_SIGMOID: st_next[S_PRE].num = (36'd1 << 32) + 36'(dsum[17:1]);
            default:
            begin
                st_next[S_PRE].num = '0;
                st_next[S_PRE].den = 18'(nau_pkg::ONE_Q16);
            end
        endcase
        st_next[S_PRE].rmd = st_next[S_PRE].num[35:18];
    end

    // restoring divider, one quotient bit per stage
    for (genvar gd = 0; gd < nau_pkg::DIV_STEPS; gd++)
    begin : g_div
        logic [18:0] trial;
        always_comb
        begin
            trial = {st_reg[S_DIV0+gd-1].rmd,
                     st_reg[S_DIV0+gd-1].num[nau_pkg::DIV_STEPS-1-gd]};
            st_next[S_DIV0+gd] = st_reg[S_DIV0+gd-1];
            if (trial >= {1'b0, st_reg[S_DIV0+gd-1].den})
            begin
                st_next[S_DIV0+gd].rmd = 18'(trial - {1'b0, st_reg[S_DIV0+gd-1].den});
                st_next[S_DIV0+gd].quo = {st_reg[S_DIV0+gd-1].quo[16:0], 1'b1};
            end
            else
            begin
                st_next[S_DIV0+gd].rmd = trial[17:0];
                st_next[S_DIV0+gd].quo = {st_reg[S_DIV0+gd-1].quo[16:0], 1'b0};
            end
        end
    end

    // activation from the quotient, operands for the final multiply
    logic [17:0]        tq;
    logic signed [17:0] tv;
    logic signed [17:0] yv;
    always_comb
    begin
        tq = 18'((19'(st_reg[S_ACT-1].quo) + 19'd1) >> 1);
        tv = st_reg[S_ACT-1].neg ? -$signed(tq) : $signed(tq);
        yv = st_reg[S_ACT-1].neg ? 18'sd65536 - $signed(st_reg[S_ACT-1].quo)
                                 : $signed(st_reg[S_ACT-1].quo);
        st_next[S_ACT]      = st_reg[S_ACT-1];
        st_next[S_ACT].op_a = '0;
        st_next[S_ACT].op_b = '0;
        unique case (st_reg[S_ACT-1].kind)
            nau_pkg::KIND_TANH:
            begin
                st_next[S_ACT].act  = 32'(tv);
                st_next[S_ACT].op_a = tv;
                st_next[S_ACT].op_b = tv;
            end
            nau_pkg::KIND_SIGMOID:
            begin
                st_next[S_ACT].act  = 32'(yv);
                st_next[S_ACT].op_a = yv;
                st_next[S_ACT].op_b = 18'sd65536 - yv;
            end
            nau_pkg::KIND_SQUARE:
            begin
                st_next[S_ACT].op_a = 18'(st_reg[S_ACT-1].x);
                st_next[S_ACT].op_b = 18'(st_reg[S_ACT-1].x);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        st_next[S_PRD]    = st_reg[S_PRD-1];
        st_next[S_PRD].pm = 36'(st_reg[S_PRD-1].op_a) * 36'(st_reg[S_PRD-1].op_b);
    end

    // final select and saturation
    logic signed [49:0] sv_raw;
    logic signed [49:0] sv_shr;
    always_comb
    begin
        sv_raw = -50'(st_reg[S_OUT-1].sp) + 50'sd512;
        sv_shr = sv_raw >>> 10;
        st_next[S_OUT]     = st_reg[S_OUT-1];
        st_next[S_OUT].ovf = 1'b0;
        unique case (st_reg[S_OUT-1].kind)
            nau_pkg::KIND_TANH:
            begin
                st_next[S_OUT].slope = nau_pkg::ONE_Q16 -
                                       32'((st_reg[S_OUT-1].pm + 36'sd32768) >>> 16);
                st_next[S_OUT].ovf   = st_reg[S_OUT-1].e_ovf;
            end
            nau_pkg::KIND_SIGMOID:
            begin
                st_next[S_OUT].slope = 32'((st_reg[S_OUT-1].pm + 36'sd32768) >>> 16);
                st_next[S_OUT].ovf   = st_reg[S_OUT-1].e_ovf;
            end
            nau_pkg::KIND_SHIFT_EXP:
            begin
                st_next[S_OUT].act = $signed(st_reg[S_OUT-1].e_val);
                if (sv_shr > 50'(nau_pkg::SAT_MAX))
                begin
                    st_next[S_OUT].slope = nau_pkg::SAT_MAX;
                    st_next[S_OUT].ovf   = 1'b1;
                end
                else if (sv_shr < 50'(nau_pkg::SAT_MIN))
                begin
                    st_next[S_OUT].slope = nau_pkg::SAT_MIN;
                    st_next[S_OUT].ovf   = 1'b1;
                end
                else
                begin
                    st_next[S_OUT].slope = sv_shr[31:0];
                    st_next[S_OUT].ovf   = st_reg[S_OUT-1].e_ovf;
                end
            end
            nau_pkg::KIND_SQUARE:
            begin
                st_next[S_OUT].act   = 32'((st_reg[S_OUT-1].pm + 36'sd8) >>> 4);
                st_next[S_OUT].slope = 32'(st_reg[S_OUT-1].x) <<< 7;
            end
            nau_pkg::KIND_EXP:
            begin
                st_next[S_OUT].act   = $signed(st_reg[S_OUT-1].e_val);
                st_next[S_OUT].slope = $signed(st_reg[S_OUT-1].e_val);
                st_next[S_OUT].ovf   = st_reg[S_OUT-1].e_ovf;
            end
            default:
            begin
                st_next[S_OUT].act   = 32'(st_reg[S_OUT-1].x) <<< 6;
                st_next[S_OUT].slope = nau_pkg::ONE_Q16;
            end
        endcase
    end

endmodule

@@ sv/nau_checker.sv @@
module nau_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] activation,
    input logic signed [31:0] slope,
    input logic               overflow
);

    // samples taken but not yet delivered
    logic [7:0] cnt_reg;
    logic [7:0] cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(activation) && $stable(slope)
                                    && $stable(overflow))
        else $error("stalled result changed");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> cnt_reg != 8'd0)
        else $error("result transfer without a sample in flight");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while result slot empty");

    a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> activation == 32'sh7FFF_FFFF || slope == 32'sh7FFF_FFFF
                                  || slope == 32'sh8000_0000)
        else $error("overflow flagged on unsaturated result");

endmodule

bind neural_activation_unit nau_checker u_nau_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .activation (result.activation_out),
    .slope      (result.slope_out),
    .overflow   (result.overflow)
);
